// ----- rtl/core/cba_pkg.sv -----
// ----------------------------------------------------------------------------
// Contiguous block allocator package
// Shared widths, status codes and the request record for the allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int LEN_W = 23;
    localparam int BB_W = 13;
    localparam int LIM_W = 11;
    localparam int TOT_W = 11;
    localparam int FIRST_W = 10;
    localparam int BLOCK_CAP = 1024;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    localparam logic [0:0] CFG_BLOCK_BYTES = 1'b0;
    localparam logic [0:0] CFG_BLOCKS_IN_USE = 1'b1;

    typedef struct packed {
        t_op                 op;
        logic [TOT_W-1:0]    total;
        logic [FIRST_W-1:0]  first;
    } t_req;

endpackage

// ----- rtl/core/cba_front.sv -----
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts requests and rounds the byte length up to whole blocks by a
// restoring divider that takes one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cba_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [22:0]           i_len,
    input  logic [9:0]            i_first,
    input  logic [12:0]           i_block_bytes,
    output logic                  o_req_valid,
    input  logic                  i_req_ready,
    output cba_pkg::t_req         o_req
);
    import cba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [LEN_W-1:0] r_quo, n_quo;
    logic [BB_W:0] r_rem, n_rem;
    logic [BB_W-1:0] r_div, n_div;
    logic [4:0] r_cnt, n_cnt;
    logic r_op, n_op;
    logic [FIRST_W-1:0] r_first, n_first;
    logic r_round, n_round;
    logic [BB_W:0] w_shift;
    logic [LEN_W:0] w_q1;

    assign o_ready = (r_state == S_IDLE);
    assign o_req_valid = (r_state == S_OUT);
    assign w_shift = {r_rem[BB_W-1:0], r_quo[LEN_W-1]};
    assign w_q1 = {1'b0, r_quo} + {{LEN_W{1'b0}}, r_round};

    always_comb begin
        o_req.op = t_op'(r_op);
        o_req.first = r_first;
        o_req.total = (w_q1 > (LEN_W+1)'(2047)) ? TOT_W'(2047) : w_q1[TOT_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_quo = r_quo;
        n_rem = r_rem;
        n_div = r_div;
        n_cnt = r_cnt;
        n_op = r_op;
        n_first = r_first;
        n_round = r_round;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_quo = i_len;
                    n_rem = '0;
                    n_div = (i_block_bytes == '0) ? BB_W'(1) : i_block_bytes;
                    n_cnt = 5'(LEN_W);
                    n_op = i_op;
                    n_first = i_first;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_shift >= {1'b0, r_div}) begin
                    n_rem = w_shift - {1'b0, r_div};
                    n_quo = {r_quo[LEN_W-2:0], 1'b1};
                end else begin
                    n_rem = w_shift;
                    n_quo = {r_quo[LEN_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_round = (n_rem != '0);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_req_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cnt <= n_cnt;
        r_op <= n_op;
        r_first <= n_first;
        r_round <= n_round;
    end

`ifndef SYNTH
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_DIV && r_cnt == 5'(LEN_W)))
        else $error("divider did not start");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_div}))
        else $error("remainder out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_req_ready) |=> (r_state == S_OUT && $stable(o_req)))
        else $error("request changed while stalled");
`endif

endmodule

// ----- rtl/core/cba_queue.sv -----
// ----------------------------------------------------------------------------
// Allocator request queue
// Two-entry queue between the front end and the bitmap engine.
// ----------------------------------------------------------------------------
module cba_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cba_pkg::t_req i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cba_pkg::t_req o_data
);
    import cba_pkg::*;

    t_req r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef SYNTH
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("queue pop lost");
`endif

endmodule

// ----- rtl/core/cba_back.sv -----
// ----------------------------------------------------------------------------
// Allocator bitmap engine
// Holds the used bitmap in a memory, recounts on limit changes, scans for
// the lowest free run, marks or clears runs and returns one result word.
// ----------------------------------------------------------------------------
module cba_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  cba_pkg::t_req               i_req,
    input  logic                        i_lim_wr,
    input  logic [10:0]                 i_lim,
    output logic                        o_cfg_ready,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [1:0]                  o_status,
    output logic [9:0]                  o_start,
    output logic [10:0]                 o_total,
    output logic [10:0]                 o_free
);
    import cba_pkg::*;

    localparam int AW = $clog2(BLOCK_CAP);
    localparam int CW = AW + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_COUNT = 8'b00000010,
        S_IDLE  = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_MARK  = 8'b00010000,
        S_FREE  = 8'b00100000,
        S_DONE  = 8'b01000000,
        S_FWAIT = 8'b10000000
    } t_state;

    t_state r_state;
    logic r_mem [BLOCK_CAP];
    logic r_rd;
    logic [CW-1:0] r_lim, r_idx, r_run, r_free, r_end, r_start;
    logic r_rdv;
    t_req r_req;
    logic [1:0] r_status;
    logic r_out_v;
    logic r_lim_cnt;
    logic [CW-1:0] w_cap;
    logic [CW-1:0] w_addr;
    logic w_we, w_wd;
    logic [CW:0] w_run1;

    assign w_cap = (i_lim > 11'(BLOCK_CAP)) ? CW'(BLOCK_CAP) : CW'(i_lim);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_req_ready = (r_state == S_IDLE) && !r_out_v && !i_lim_wr;
    assign o_res_valid = r_out_v;
    assign o_status = r_status;
    assign o_start = 10'(r_start);
    assign o_total = r_req.total;
    assign o_free = 11'(r_free);
    assign w_run1 = {1'b0, r_run} + {{CW{1'b0}}, 1'b1};

    always_comb begin
        w_addr = r_idx;
        w_we = 1'b0;
        w_wd = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_MARK: begin
                w_we = 1'b1;
                w_wd = 1'b1;
            end
            S_FREE: begin
                w_we = r_rdv && r_rd;
                w_addr = r_idx - CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr[AW-1:0]] <= w_wd;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= '0;
            r_lim <= CW'(BLOCK_CAP);
            r_out_v <= 1'b0;
            r_rdv <= 1'b0;
            r_free <= '0;
        end else begin
            if (r_out_v && i_res_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == CW'(BLOCK_CAP - 1)) begin
                        r_state <= S_IDLE;
                        r_free <= r_lim;
                    end
                end
                S_IDLE: begin
                    r_rdv <= 1'b0;
                    r_idx <= '0;
                    r_run <= '0;
                    if (!r_out_v && i_lim_wr) begin
                        r_lim <= w_cap;
                        r_free <= '0;
                        r_state <= S_COUNT;
                    end else if (!r_out_v && i_req_valid) begin
                        r_req <= i_req;
                        r_status <= ST_OK;
                        r_start <= '0;
                        if (i_req.op == OP_ALLOC) begin
                            if ({1'b0, i_req.total} > 12'(r_lim)) begin
                                r_status <= ST_NOSPACE;
                                r_state <= S_DONE;
                            end else if (i_req.total == '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            if ((12'(i_req.first) + 12'(i_req.total)) > 12'(r_lim)) begin
                                r_status <= ST_RANGE;
                                r_state <= S_DONE;
                            end else begin
                                r_start <= CW'(i_req.first);
                                r_idx <= CW'(i_req.first);
                                r_end <= CW'(12'(i_req.first) + 12'(i_req.total));
                                r_state <= S_FREE;
                            end
                        end
                    end
                end
                S_COUNT: begin
                    r_rdv <= 1'b1;
                    if (r_rdv && !r_rd) begin
                        r_free <= r_free + CW'(1);
                    end
                    if (r_idx == r_lim) begin
                        r_state <= S_FWAIT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_FWAIT: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_rdv <= 1'b1;
                    if (r_rdv) begin
                        if (r_rd) begin
                            r_run <= '0;
                        end else begin
                            r_run <= w_run1[CW-1:0];
                            if (w_run1 == (CW+1)'(r_req.total)) begin
                                r_start <= r_idx - CW'(r_req.total);
                                r_idx <= r_idx - CW'(r_req.total);
                                r_end <= r_idx;
                                r_free <= r_free - CW'(r_req.total);
                                r_state <= S_MARK;
                            end
                        end
                    end
                    if (r_state == S_SCAN && !(r_rdv && !r_rd &&
                            w_run1 == (CW+1)'(r_req.total))) begin
                        if (r_idx == r_lim) begin
                            r_status <= ST_NOSPACE;
                            r_start <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                S_MARK: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_FREE: begin
                    r_rdv <= 1'b1;
                    if (r_rdv && r_rd) begin
                        r_free <= r_free + CW'(1);
                    end
                    if (r_idx == r_end) begin
                        r_state <= S_FWAIT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_DONE: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_FWAIT && r_req.op == OP_RELEASE && !r_lim_cnt) begin
                r_out_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_cnt <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_lim_cnt <= !r_out_v && i_lim_wr;
        end
    end

`ifndef SYNTH
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_free <= r_lim)) else $error("free count above limit");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !o_req_ready) else $error("accepted while result pending");
`endif

endmodule

// ----- rtl/core/contiguous_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Contiguous block allocator
// First-fit allocator over a block bitmap with length rounding and release.
//
// Channel   Direction  Contents
// s_axis    in         tdata {first_block, length_bytes, operation}
// m_axis    out        tdata {free_blocks, block_total, start_block, status}
// cfg       in         index 0 block_bytes, index 1 blocks_in_use
//
// The divider rounds a length up to whole blocks; the bitmap engine reads one block
// per cycle, so an allocate scans at most up to the block limit and then
// marks one block per cycle, and a release reads and clears its run.
// After reset the engine clears the whole bitmap before it accepts.
// A limit write recounts free blocks over the new limit.
// A waiting result holds the engine; the two-word queue then fills and stalls.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // operation, length_bytes, first_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status, start_block, block_total, free_blocks
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import cba_pkg::*;

    logic [BB_W-1:0] r_block_bytes;
    logic w_fv, w_fr, w_qv, w_qr, w_cfg_rdy, w_lim_wr;
    t_req w_freq, w_qreq;
    logic [1:0] w_st;
    logic [9:0] w_start;
    logic [10:0] w_tot, w_free;

    assign o_cfg_ready = w_cfg_rdy;
    assign w_lim_wr = i_cfg_valid && (i_cfg_index == CFG_BLOCKS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BB_W'(64);
        end else if (i_cfg_valid && w_cfg_rdy && i_cfg_index == CFG_BLOCK_BYTES) begin
            r_block_bytes <= i_cfg_data;
        end
    end

    cba_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[0]), .i_len(s_axis_tdata[23:1]), .i_first(s_axis_tdata[33:24]),
        .i_block_bytes(r_block_bytes),
        .o_req_valid(w_fv), .i_req_ready(w_fr), .o_req(w_freq)
    );

    cba_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_data(w_freq),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qreq)
    );

    cba_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(w_qv), .o_req_ready(w_qr), .i_req(w_qreq),
        .i_lim_wr(w_lim_wr), .i_lim(i_cfg_data[LIM_W-1:0]), .o_cfg_ready(w_cfg_rdy),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_status(w_st), .o_start(w_start), .o_total(w_tot), .o_free(w_free)
    );

    assign m_axis_tdata = {6'b0, w_free, w_tot, w_start, w_st};

`ifndef SYNTH
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !m_axis_tvalid) else $error("config ready with result pending");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tdata[39:34] == 6'b0) else $error("padding not zero");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");
`endif

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Contiguous block allocator testbench
// Drives allocate and release words through the input stream, predicts every
// result with a first-fit bitmap model kept here, and compares each result
// word field by field. Block size and block limit are changed between phases
// while the allocator is idle. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cba_pkg::*;

    localparam int NBLK = BLOCK_CAP;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [LIM_W-1:0]   free_blocks;
        logic [TOT_W-1:0]   total;
        logic [FIRST_W-1:0] start;
        t_status            status;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    contiguous_block_allocator_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    logic [39:0]   pending_words[$];
    t_alloc_result expected_results[$];
    bit            used_bits[NBLK];
    int unsigned   blk_size = 64;
    int unsigned   blk_limit = 1024;
    int unsigned   free_total = 1024;
    int            fail_count = 0;
    int            words_in = 0;
    int            words_out = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    int            hold_cycles = 0;
    bit            hold_req = 1'b0;
    bit            hold_used = 1'b0;
    bit            in_taken = 1'b0;
    bit            stalls_on = 1'b1;
    bit            send_paused = 1'b0;

    function automatic int unsigned usable_limit();
        return blk_limit > NBLK ? NBLK : blk_limit;
    endfunction

    function automatic void recount_free();
        free_total = 0;
        for (int i = 0; i < usable_limit(); i++)
            if (!used_bits[i]) free_total++;
    endfunction

    function automatic t_alloc_result allocate_or_release(logic [39:0] word);
        t_alloc_result r;
        t_op           op;
        longint unsigned len, bsz, tot64;
        int unsigned   first, total, lim, run, start;
        bit            found;
        op = t_op'(word[0]);
        len = 64'(word[23:1]);
        first = 32'(word[33:24]);
        bsz = blk_size == 0 ? 1 : blk_size;
        tot64 = (len + bsz - 1) / bsz;
        total = tot64 > 2047 ? 2047 : 32'(tot64);
        lim = usable_limit();
        r.status = ST_OK;
        start = 0;
        if (op == OP_ALLOC) begin
            if (total > lim) begin
                r.status = ST_NOSPACE;
            end else if (total > 0) begin
                run = 0;
                found = 1'b0;
                for (int i = 0; i < lim; i++) begin
                    run = used_bits[i] ? 0 : run + 1;
                    if (run == total) begin
                        start = i + 1 - total;
                        found = 1'b1;
                        break;
                    end
                end
                if (found) begin
                    for (int i = start; i < start + total; i++) used_bits[i] = 1'b1;
                    free_total -= total;
                end else begin
                    r.status = ST_NOSPACE;
                end
            end
        end else begin
            if (first + total > lim) begin
                r.status = ST_RANGE;
            end else begin
                for (int i = first; i < first + total; i++) begin
                    if (used_bits[i]) begin
                        used_bits[i] = 1'b0;
                        free_total++;
                    end
                end
                start = first;
            end
        end
        r.start = FIRST_W'(start);
        r.total = TOT_W'(total);
        r.free_blocks = LIM_W'(free_total);
        return r;
    endfunction

    function automatic logic [39:0] pack_word(t_op op, int unsigned len, int unsigned first);
        logic [39:0] w;
        w = '0;
        w[0] = op;
        w[23:1] = 23'(len);
        w[33:24] = 10'(first);
        return w;
    endfunction

    always @(negedge i_clk) begin
        if (s_axis_tvalid && !in_taken) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0 && !send_paused) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= pending_words.pop_front();
            if (stalls_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 13);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_cycles <= 3000;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 13);
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result got, exp_r;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(allocate_or_release(s_axis_tdata));
            words_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[33:0];
            words_out++;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result word: expected none actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status)
                    $display("%0t status expected %0d actual %0d",
                             $time, exp_r.status, got.status);
                if (got.start !== exp_r.start)
                    $display("%0t start_block expected %0d actual %0d",
                             $time, exp_r.start, got.start);
                if (got.total !== exp_r.total)
                    $display("%0t block_total expected %0d actual %0d",
                             $time, exp_r.total, got.total);
                if (got.free_blocks !== exp_r.free_blocks)
                    $display("%0t free_blocks expected %0d actual %0d",
                             $time, exp_r.free_blocks, got.free_blocks);
                if (got !== exp_r) fail_count++;
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("%0t watchdog: no progress", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 13'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_BLOCK_BYTES) begin
            blk_size = value;
        end else begin
            blk_limit = value;
            recount_free();
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic queue_random(int count);
        int unsigned bsz, lim, op, len, first, nblk;
        for (int n = 0; n < count; n++) begin
            bsz = blk_size == 0 ? 1 : blk_size;
            lim = usable_limit();
            op = $urandom_range(0, 2) == 0 ? OP_RELEASE : OP_ALLOC;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(0, 23'h7fffff);
                1: len = 0;
                default: begin
                    nblk = $urandom_range(1, lim > 16 ? 16 : lim + 1);
                    len = nblk * bsz - $urandom_range(0, bsz - 1);
                end
            endcase
            first = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                              : $urandom_range(0, lim > 0 ? lim - 1 : 0);
            pending_words.push_back(pack_word(t_op'(op), len, first));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, both operations, corner cases at reset settings.
        pending_words.push_back(pack_word(OP_ALLOC, 0, 0));
        pending_words.push_back(pack_word(OP_ALLOC, 1, 1023));
        pending_words.push_back(pack_word(OP_ALLOC, 64, 0));
        pending_words.push_back(pack_word(OP_ALLOC, 65, 0));
        pending_words.push_back(pack_word(OP_ALLOC, 23'h7fffff, 0));
        pending_words.push_back(pack_word(OP_ALLOC, 64 * 1024, 0));
        pending_words.push_back(pack_word(OP_RELEASE, 64, 1));
        pending_words.push_back(pack_word(OP_RELEASE, 64, 1));
        pending_words.push_back(pack_word(OP_RELEASE, 0, 1023));
        pending_words.push_back(pack_word(OP_RELEASE, 128, 1023));
        pending_words.push_back(pack_word(OP_RELEASE, 23'h7fffff, 0));
        pending_words.push_back(pack_word(OP_ALLOC, 64, 0));
        pending_words.push_back(pack_word(OP_RELEASE, 64 * 1024, 0));
        pending_words.push_back(pack_word(OP_ALLOC, 23'h555555, 10'h2aa));
        pending_words.push_back(pack_word(OP_RELEASE, 23'h2aaaaa, 10'h155));
        drain();

        // Block size zero, tiny limit, limit beyond capacity, limit of zero.
        write_reg(CFG_BLOCK_BYTES, 0);
        write_reg(CFG_BLOCKS_IN_USE, 8);
        queue_random(40);
        drain();
        write_reg(CFG_BLOCKS_IN_USE, 0);
        pending_words.push_back(pack_word(OP_ALLOC, 1, 0));
        pending_words.push_back(pack_word(OP_RELEASE, 0, 0));
        pending_words.push_back(pack_word(OP_RELEASE, 1, 0));
        drain();
        write_reg(CFG_BLOCKS_IN_USE, 2047);
        write_reg(CFG_BLOCK_BYTES, 8191);
        queue_random(60);
        drain();

        // Receiver held off while the sender keeps offering.
        write_reg(CFG_BLOCK_BYTES, 4096);
        write_reg(CFG_BLOCKS_IN_USE, 64);
        hold_req = 1'b1;
        queue_random(80);
        drain();

        // Sender pause until everything is back, then more traffic.
        write_reg(CFG_BLOCK_BYTES, 1);
        write_reg(CFG_BLOCKS_IN_USE, 1);
        queue_random(40);
        drain();
        write_reg(CFG_BLOCK_BYTES, 64);
        write_reg(CFG_BLOCKS_IN_USE, 1024);
        queue_random(120);
        wait (pending_words.size() <= 60);
        send_paused = 1'b1;
        wait (expected_results.size() == 0 && !s_axis_tvalid);
        repeat (50) @(posedge i_clk);
        send_paused = 1'b0;
        drain();

        write_reg(CFG_BLOCK_BYTES, 1000);
        write_reg(CFG_BLOCKS_IN_USE, 200);
        queue_random(120);
        drain();

        stalls_on = 1'b0;
        write_reg(CFG_BLOCK_BYTES, 512);
        write_reg(CFG_BLOCKS_IN_USE, 512);
        queue_random(60);
        drain();

        $display("Run covered %0d request words and %0d result words", words_in, words_out);
        $display("over block sizes 0 to 8191 and block limits 0 to 2047, with stalls.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/cba_pkg.sv
rtl/core/cba_front.sv
rtl/core/cba_queue.sv
rtl/core/cba_back.sv
rtl/core/contiguous_block_allocator_top.sv
sim/testbench.sv
